@@ src/arfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arfb_pkg;

    // Largest sample count that a frame can announce.
    localparam logic [5:0] ARFB_MAX_SAMPLES = 6'd58;

    // Depth of the job queue between the front and the back part.
    localparam int ARFB_QDEPTH = 2;
    localparam int ARFB_QAW    = (ARFB_QDEPTH > 1) ? $clog2(ARFB_QDEPTH) : 1;

    // Characters of the frame.
    localparam logic [7:0] ARFB_CH_TILDE = 8'h7E;
    localparam logic [7:0] ARFB_CH_ZERO  = 8'h30;
    localparam logic [7:0] ARFB_CH_ONE   = 8'h31;
    localparam logic [7:0] ARFB_CH_LOWA  = 8'h61;
    localparam logic [7:0] ARFB_CH_CR    = 8'h0D;

    // Saturation limits of the decimal fields.
    localparam logic [13:0] ARFB_LIM_2DIG = 14'd99;
    localparam logic [13:0] ARFB_LIM_3DIG = 14'd999;
    localparam logic [13:0] ARFB_LIM_4DIG = 14'd9999;

    // Reflected CRC-8 polynomial.
    localparam logic [7:0] ARFB_CRC_POLY = 8'h8C;

    // Input command codes.
    localparam logic ARFB_CMD_START  = 1'b0;
    localparam logic ARFB_CMD_SAMPLE = 1'b1;

    // Kind of work handed from the front part to the back part.
    typedef enum logic {
        JOB_HEAD,
        JOB_SAMP
    } t_job_kind;

    // One queued job; decimal fields are already saturated.
    typedef struct packed {
        t_job_kind   kind;
        logic        close;
        logic [13:0] len;
        logic [13:0] err;
        logic [13:0] power;
        logic [13:0] sample;
    } t_job;

    // Byte sequencer phases of the back part.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_SAMP,
        PH_CLOSE
    } t_phase;

    // Place value of the digit being printed.
    typedef enum logic [1:0] {
        DIV_1000,
        DIV_100,
        DIV_10,
        DIV_1
    } t_div;

endpackage

`default_nettype wire

@@ src/arfb_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface arfb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [6:0]  err_code;
    logic [9:0]  power_level;
    logic [5:0]  sample_count;
    logic [15:0] sample;

    modport source (
        output valid, cmd, err_code, power_level, sample_count, sample,
        input  ready
    );

    modport sink (
        input  valid, cmd, err_code, power_level, sample_count, sample,
        output ready
    );
endinterface

`default_nettype wire

@@ src/arfb_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface arfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (
        output valid, out_byte, frame_end,
        input  ready
    );

    modport sink (
        input  valid, out_byte, frame_end,
        output ready
    );
endinterface

`default_nettype wire

@@ src/arfb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arfb_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    arfb_in_if.sink           i_in,
    input  wire logic         i_q_full,
    output logic              o_q_push,
    output arfb_pkg::t_job    o_q_job
);

    logic [5:0] r_left;
    logic [5:0] n_left;
    logic       s_acc;
    logic [5:0] s_count;

    // An item is taken whenever the queue has room.
    assign i_in.ready = !i_q_full;
    assign s_acc      = i_in.valid && !i_q_full;

    assign s_count = (i_in.sample_count > arfb_pkg::ARFB_MAX_SAMPLES)
                   ? arfb_pkg::ARFB_MAX_SAMPLES : i_in.sample_count;

    // Build the job with all decimal fields saturated.
    always_comb begin
        o_q_job.kind  = (i_in.cmd == arfb_pkg::ARFB_CMD_START)
                      ? arfb_pkg::JOB_HEAD : arfb_pkg::JOB_SAMP;
        o_q_job.close = (i_in.cmd == arfb_pkg::ARFB_CMD_START)
                      ? (s_count == 6'd0) : (r_left == 6'd1);
        o_q_job.len   = 14'd7 + {6'd0, s_count, 2'b00};
        o_q_job.err   = ({7'd0, i_in.err_code} > arfb_pkg::ARFB_LIM_2DIG)
                      ? arfb_pkg::ARFB_LIM_2DIG : {7'd0, i_in.err_code};
        o_q_job.power = ({4'd0, i_in.power_level} > arfb_pkg::ARFB_LIM_3DIG)
                      ? arfb_pkg::ARFB_LIM_3DIG : {4'd0, i_in.power_level};
        o_q_job.sample = (i_in.sample > 16'(arfb_pkg::ARFB_LIM_4DIG))
                       ? arfb_pkg::ARFB_LIM_4DIG : i_in.sample[13:0];
    end

    // A sample outside an open frame is taken and dropped.
    always_comb begin
        o_q_push = 1'b0;
        n_left   = r_left;
        if (s_acc) begin
            if (i_in.cmd == arfb_pkg::ARFB_CMD_START) begin
                o_q_push = 1'b1;
                n_left   = s_count;
            end else if (r_left != 6'd0) begin
                o_q_push = 1'b1;
                n_left   = r_left - 6'd1;
            end
        end
    end

    // Samples still expected in the open frame; zero means no frame is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 6'd0;
        end else begin
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

@@ src/arfb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arfb_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire arfb_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output arfb_pkg::t_job      o_data,
    output logic                o_empty
);

    arfb_pkg::t_job                r_mem [arfb_pkg::ARFB_QDEPTH];
    logic [arfb_pkg::ARFB_QAW-1:0] r_wr;
    logic [arfb_pkg::ARFB_QAW-1:0] r_rd;
    logic [arfb_pkg::ARFB_QAW:0]   r_cnt;
    logic                          s_wr_en;
    logic                          s_rd_en;

    assign o_full  = (r_cnt == (arfb_pkg::ARFB_QAW+1)'(arfb_pkg::ARFB_QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign s_wr_en = i_push && !o_full;
    assign s_rd_en = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_wr_en) begin
                r_wr <= (r_wr == arfb_pkg::ARFB_QAW'(arfb_pkg::ARFB_QDEPTH - 1))
                      ? '0 : r_wr + arfb_pkg::ARFB_QAW'(1);
            end
            if (s_rd_en) begin
                r_rd <= (r_rd == arfb_pkg::ARFB_QAW'(arfb_pkg::ARFB_QDEPTH - 1))
                      ? '0 : r_rd + arfb_pkg::ARFB_QAW'(1);
            end
            if (s_wr_en && !s_rd_en) begin
                r_cnt <= r_cnt + (arfb_pkg::ARFB_QAW+1)'(1);
            end else if (s_rd_en && !s_wr_en) begin
                r_cnt <= r_cnt - (arfb_pkg::ARFB_QAW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/arfb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arfb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [9:0]     i_dev_addr,
    input  wire logic [6:0]     i_dev_type,
    input  wire logic           i_q_empty,
    input  wire arfb_pkg::t_job i_q_job,
    output logic                o_q_pop,
    arfb_out_if.source          o_out
);

    arfb_pkg::t_phase r_phase;
    arfb_pkg::t_phase n_phase;
    logic [4:0]       r_idx;
    logic [4:0]       n_idx;
    arfb_pkg::t_job   r_job;
    arfb_pkg::t_job   n_job;
    logic [13:0]      r_val;
    logic [13:0]      n_val;
    logic [7:0]       r_crc;
    logic [7:0]       n_crc;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;

    logic             s_adv;
    logic             s_load;
    logic [7:0]       s_byte;
    logic             s_digit;
    arfb_pkg::t_div   s_dsel;
    logic             s_first;
    logic [13:0]      s_src;
    logic             s_last;
    logic             s_end;
    logic             s_crc_en;
    logic [13:0]      s_vin;
    logic [13:0]      s_thr;
    logic [3:0]       s_dig;
    logic [13:0]      s_rem;
    logic [13:0]      s_addr;
    logic [13:0]      s_type;

    // One CRC-8 step over a whole byte, LSB first.
    function automatic logic [7:0] f_crc8(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ arfb_pkg::ARFB_CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // Lowercase hex character of a nibble.
    function automatic logic [7:0] f_hex(input logic [3:0] n);
        return (n < 4'd10) ? (arfb_pkg::ARFB_CH_ZERO + {4'd0, n})
                           : (arfb_pkg::ARFB_CH_LOWA + {4'd0, n} - 8'd10);
    endfunction

    assign s_addr = ({4'd0, i_dev_addr} > arfb_pkg::ARFB_LIM_3DIG)
                  ? arfb_pkg::ARFB_LIM_3DIG : {4'd0, i_dev_addr};
    assign s_type = ({7'd0, i_dev_type} > arfb_pkg::ARFB_LIM_2DIG)
                  ? arfb_pkg::ARFB_LIM_2DIG : {7'd0, i_dev_type};

    // While a job is active, a byte is produced whenever the output register is free or drains.
    assign s_adv = (r_phase != arfb_pkg::PH_IDLE) && (!r_out_valid || o_out.ready);

    // Decode of the current byte position.
    always_comb begin
        s_byte   = arfb_pkg::ARFB_CH_TILDE;
        s_digit  = 1'b0;
        s_dsel   = arfb_pkg::DIV_1;
        s_first  = 1'b0;
        s_src    = r_val;
        s_last   = 1'b0;
        s_end    = 1'b0;
        s_crc_en = 1'b0;
        unique case (r_phase)
            arfb_pkg::PH_HEAD: begin
                s_crc_en = 1'b1;
                s_last   = (r_idx == 5'd16);
                case (r_idx)
                    5'd0: s_byte = arfb_pkg::ARFB_CH_TILDE;
                    5'd1: begin
                        s_digit = 1'b1; s_dsel = arfb_pkg::DIV_100;
                        s_first = 1'b1; s_src = s_addr;
                    end
                    5'd2: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_10; end
                    5'd3: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_1; end
                    5'd4: s_byte = arfb_pkg::ARFB_CH_ZERO;
                    5'd5: s_byte = arfb_pkg::ARFB_CH_ONE;
                    5'd6: begin
                        s_digit = 1'b1; s_dsel = arfb_pkg::DIV_1000;
                        s_first = 1'b1; s_src = r_job.len;
                    end
                    5'd7: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_100; end
                    5'd8: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_10; end
                    5'd9: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_1; end
                    5'd10: begin
                        s_digit = 1'b1; s_dsel = arfb_pkg::DIV_10;
                        s_first = 1'b1; s_src = s_type;
                    end
                    5'd11: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_1; end
                    5'd12: begin
                        s_digit = 1'b1; s_dsel = arfb_pkg::DIV_10;
                        s_first = 1'b1; s_src = r_job.err;
                    end
                    5'd13: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_1; end
                    5'd14: begin
                        s_digit = 1'b1; s_dsel = arfb_pkg::DIV_100;
                        s_first = 1'b1; s_src = r_job.power;
                    end
                    5'd15: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_10; end
                    5'd16: begin s_digit = 1'b1; s_dsel = arfb_pkg::DIV_1; end
                    default: s_byte = arfb_pkg::ARFB_CH_TILDE;
                endcase
            end
            arfb_pkg::PH_SAMP: begin
                s_crc_en = 1'b1;
                s_digit  = 1'b1;
                s_last   = (r_idx == 5'd3);
                case (r_idx)
                    5'd0: begin
                        s_dsel = arfb_pkg::DIV_1000; s_first = 1'b1; s_src = r_job.sample;
                    end
                    5'd1:    s_dsel = arfb_pkg::DIV_100;
                    5'd2:    s_dsel = arfb_pkg::DIV_10;
                    default: s_dsel = arfb_pkg::DIV_1;
                endcase
            end
            arfb_pkg::PH_CLOSE: begin
                s_last = (r_idx == 5'd2);
                case (r_idx)
                    5'd0: s_byte = f_hex(r_crc[7:4]);
                    5'd1: s_byte = f_hex(r_crc[3:0]);
                    default: begin
                        s_byte = arfb_pkg::ARFB_CH_CR;
                        s_end  = 1'b1;
                    end
                endcase
            end
            default: s_byte = arfb_pkg::ARFB_CH_TILDE;
        endcase

        // Digit by parallel compare against the multiples of the place value.
        s_vin = s_first ? s_src : r_val;
        s_dig = 4'd0;
        s_rem = s_vin;
        for (int k = 1; k < 10; k++) begin
            unique case (s_dsel)
                arfb_pkg::DIV_1000: s_thr = 14'(k * 1000);
                arfb_pkg::DIV_100:  s_thr = 14'(k * 100);
                arfb_pkg::DIV_10:   s_thr = 14'(k * 10);
                default:            s_thr = 14'(k);
            endcase
            if (s_vin >= s_thr) begin
                s_dig = 4'(k);
                s_rem = s_vin - s_thr;
            end
        end
        if (s_digit) begin
            s_byte = arfb_pkg::ARFB_CH_ZERO + {4'd0, s_dig};
        end
    end

    // Next state of the byte sequencer.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_job   = r_job;
        n_val   = r_val;
        n_crc   = r_crc;
        s_load  = 1'b0;
        if (r_phase == arfb_pkg::PH_IDLE) begin
            s_load = !i_q_empty;
        end else if (s_adv) begin
            n_idx = r_idx + 5'd1;
            if (s_digit) begin
                n_val = s_rem;
            end
            if (s_crc_en) begin
                n_crc = f_crc8(r_crc, s_byte);
            end
            if (s_last) begin
                if (r_phase != arfb_pkg::PH_CLOSE && r_job.close) begin
                    n_phase = arfb_pkg::PH_CLOSE;
                    n_idx   = 5'd0;
                end else begin
                    if (r_phase == arfb_pkg::PH_CLOSE) begin
                        n_crc = 8'd0;
                    end
                    n_phase = arfb_pkg::PH_IDLE;
                    s_load  = !i_q_empty;
                end
            end
        end
        // Take the next job straight away so that jobs run back to back.
        if (s_load) begin
            n_job = i_q_job;
            n_idx = 5'd0;
            if (i_q_job.kind == arfb_pkg::JOB_HEAD) begin
                n_phase = arfb_pkg::PH_HEAD;
                n_crc   = 8'd0;
            end else begin
                n_phase = arfb_pkg::PH_SAMP;
            end
        end
        o_q_pop = s_load;
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= arfb_pkg::PH_IDLE;
            r_idx       <= 5'd0;
            r_crc       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
            if (s_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job, residual value and output payload.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_val <= n_val;
        if (s_adv) begin
            r_out_byte <= s_byte;
            r_out_end  <= s_end;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.frame_end = r_out_end;

endmodule

`default_nettype wire

@@ src/ascii_report_frame_builder.sv @@
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    cmd, err_code, power_level, sample_count, sample
// o_out     out  valid/ready    out_byte, frame_end
// APB       in   psel/penable   paddr[2] selects device_address or device_type
//
// The output gives one byte per cycle while a job is queued or running and o_out
// is not stalled: a sample prints four digits, a start item the header, and
// a frame close the CRC and a CR. Items enter a 2-entry job queue, so input is
// taken while earlier items are still being printed. Reset is synchronous
// and active low; it clears the queue, frame state and both registers.
// A stall on o_out holds the sequencer; the queue then fills and drops ready.
`timescale 1ns / 1ps
`default_nettype none

module ascii_report_frame_builder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    arfb_in_if.sink           i_in,
    arfb_out_if.source        o_out,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [9:0]     r_dev_addr;
    logic [6:0]     r_dev_type;
    logic           s_push;
    logic           s_full;
    logic           s_pop;
    logic           s_empty;
    arfb_pkg::t_job s_job_in;
    arfb_pkg::t_job s_job_out;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 10'd0;
            r_dev_type <= 7'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_dev_type <= pwdata[6:0];
            end else begin
                r_dev_addr <= pwdata[9:0];
            end
        end
    end

    assign prdata = paddr[2] ? {25'd0, r_dev_type} : {22'd0, r_dev_addr};

    // Front part: accepts and classifies items.
    arfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (s_full),
        .o_q_push (s_push),
        .o_q_job  (s_job_in)
    );

    // Job queue between the two parts.
    arfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_job_in),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_data  (s_job_out),
        .o_empty (s_empty)
    );

    // Back part: prints the frame bytes and the CRC.
    arfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dev_addr (r_dev_addr),
        .i_dev_type (r_dev_type),
        .i_q_empty  (s_empty),
        .i_q_job    (s_job_out),
        .o_q_pop    (s_pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

@@ src/arfb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arfb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_out_byte,
    input wire logic        i_frame_end,
    input wire logic        i_psel,
    input wire logic        i_penable,
    input wire logic        i_pwrite,
    input wire logic        i_pready,
    input wire logic [2:0]  i_paddr,
    input wire logic [31:0] i_pwdata,
    input wire logic [31:0] i_prdata
);

    // A stalled output item keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_frame_end))
        else $error("output item changed while stalled");

    // The frame end flag only rides on the carriage return.
    a_end_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_out_byte == arfb_pkg::ARFB_CH_CR)
        else $error("frame end on a byte other than carriage return");

    // The port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

    // A register reads back what was last written to it.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_psel && i_penable && i_pwrite && i_pready)
        && i_paddr[2] == $past(i_paddr[2])
        |-> (i_paddr[2] ? (i_prdata[6:0] == $past(i_pwdata[6:0]))
                        : (i_prdata[9:0] == $past(i_pwdata[9:0]))))
        else $error("register readback mismatch");

endmodule

bind ascii_report_frame_builder arfb_checker u_arfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_frame_end (o_out.frame_end),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_pready    (pready),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire

@@ test/tb_ascii_report_frame_builder.sv @@
`timescale 1ns / 1ps

module tb_ascii_report_frame_builder;

    // Register addresses on the configuration port.
    localparam logic [2:0] ADDR_DEVICE_ADDRESS = 3'd0;
    localparam logic [2:0] ADDR_DEVICE_TYPE    = 3'd4;

    localparam int RANDOM_ITEMS   = 460;
    localparam int SEGMENTS       = 6;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // One expected byte of the frame.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    // Predicts the byte stream of the frame builder and checks what comes out.
    class frame_checker;
        logic [9:0]  dev_address;
        logic [6:0]  dev_type;
        logic [7:0]  crc;
        int unsigned samples_left;
        bit          frame_open;
        t_frame_byte expected_bytes[$];
        int unsigned errors;

        function new();
            dev_address  = '0;
            dev_type     = '0;
            crc          = '0;
            samples_left = 0;
            frame_open   = 1'b0;
            errors       = 0;
        endfunction

        // Bitwise reflected CRC-8 update over one byte.
        function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
            c = c ^ b;
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ arfb_pkg::ARFB_CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void push_byte(logic [7:0] b, bit in_crc, bit last);
            t_frame_byte e;
            e.data = b;
            e.last = last;
            expected_bytes.push_back(e);
            if (in_crc) begin
                crc = crc_update(crc, b);
            end
        endfunction

        // Prints a value in a fixed number of digits, saturated to all nines.
        function void push_decimal(int unsigned v, int digits);
            int unsigned lim;
            int unsigned div;
            logic [7:0]  d;
            lim = 1;
            for (int k = 0; k < digits; k++) begin
                lim = lim * 10;
            end
            if (v > lim - 1) begin
                v = lim - 1;
            end
            div = lim / 10;
            for (int k = 0; k < digits; k++) begin
                d = 8'((v / div) % 10);
                push_byte(arfb_pkg::ARFB_CH_ZERO + d, 1'b1, 1'b0);
                div = div / 10;
            end
        endfunction

        function logic [7:0] hex_char(logic [3:0] nib);
            if (nib < 4'd10) begin
                return arfb_pkg::ARFB_CH_ZERO + {4'd0, nib};
            end
            return arfb_pkg::ARFB_CH_LOWA + {4'd0, nib} - 8'd10;
        endfunction

        // Appends the CRC in lowercase hex and the closing carriage return.
        function void close_frame();
            logic [7:0] c;
            c = crc;
            push_byte(hex_char(c[7:4]), 1'b0, 1'b0);
            push_byte(hex_char(c[3:0]), 1'b0, 1'b0);
            push_byte(arfb_pkg::ARFB_CH_CR, 1'b0, 1'b1);
            frame_open   = 1'b0;
            samples_left = 0;
            crc          = '0;
        endfunction

        // Queues the bytes that one accepted item causes; returns their number.
        function int predict_frame_bytes(logic cmd, logic [6:0] err, logic [9:0] power,
                                         logic [5:0] count, logic [15:0] sample);
            int queued;
            int unsigned n;
            queued = expected_bytes.size();
            if (cmd == arfb_pkg::ARFB_CMD_START) begin
                n = (count > arfb_pkg::ARFB_MAX_SAMPLES) ? arfb_pkg::ARFB_MAX_SAMPLES : count;
                crc          = '0;
                frame_open   = 1'b1;
                samples_left = n;
                push_byte(arfb_pkg::ARFB_CH_TILDE, 1'b1, 1'b0);
                push_decimal(dev_address, 3);
                push_byte(arfb_pkg::ARFB_CH_ZERO, 1'b1, 1'b0);
                push_byte(arfb_pkg::ARFB_CH_ONE, 1'b1, 1'b0);
                push_decimal(7 + 4 * n, 4);
                push_decimal(dev_type, 2);
                push_decimal(err, 2);
                push_decimal(power, 3);
                if (n == 0) begin
                    close_frame();
                end
            end else if (frame_open && samples_left != 0) begin
                push_decimal(sample, 4);
                samples_left--;
                if (samples_left == 0) begin
                    close_frame();
                end
            end
            return expected_bytes.size() - queued;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 200) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_byte(logic [7:0] b, logic last);
            t_frame_byte e;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %h (end %b) arrived with nothing expected", b, last));
            end else begin
                e = expected_bytes.pop_front();
                if (b !== e.data) begin
                    report($sformatf("out_byte %h, expected %h", b, e.data));
                end
                if (last !== e.last) begin
                    report($sformatf("frame_end %b on byte %h, expected %b", last, b, e.last));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    arfb_in_if  in_ch ();
    arfb_out_if out_ch ();

    frame_checker board;
    int           in_idle_pct;
    int           out_idle_pct;
    int           items_sent;
    int           quiet_cycles;

    ascii_report_frame_builder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The receiver stalls at random on the falling edge.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Check results and watch for a hang at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_byte(out_ch.out_byte, out_ch.frame_end);
        end
        if (i_rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offers one item, with random idle cycles ahead of it, and waits for acceptance.
    task automatic send_item(logic cmd, logic [6:0] err, logic [9:0] power,
                             logic [5:0] count, logic [15:0] sample);
        int n;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd;
        in_ch.err_code     <= err;
        in_ch.power_level  <= power;
        in_ch.sample_count <= count;
        in_ch.sample       <= sample;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        n = board.predict_frame_bytes(cmd, err, power, count, sample);
        if (n > 0) begin
            items_sent++;
        end
    endtask

    task automatic send_start(logic [5:0] count);
        send_item(arfb_pkg::ARFB_CMD_START, 7'($urandom_range(0, 127)),
                  10'($urandom_range(0, 1023)), count, 16'($urandom));
    endtask

    task automatic send_sample(logic [15:0] sample);
        send_item(arfb_pkg::ARFB_CMD_SAMPLE, 7'($urandom_range(0, 127)),
                  10'($urandom_range(0, 1023)), 6'($urandom_range(0, 63)), sample);
    endtask

    // Stops offering items, lets the output drain and the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes both registers once the block is idle; upper data bits are noise.
    task automatic set_config(int unsigned address_value, int unsigned type_value);
        logic [31:0] word;
        settle();
        word       = $urandom;
        word[9:0]  = 10'(address_value);
        write_reg(ADDR_DEVICE_ADDRESS, word);
        board.dev_address = word[9:0];
        word       = $urandom;
        word[6:0]  = 7'(type_value);
        write_reg(ADDR_DEVICE_TYPE, word);
        board.dev_type = word[6:0];
    endtask

    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 16'($urandom_range(0, 9999));
        end else if (r < 90) begin
            return 16'($urandom);
        end
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd9999;
            2: return 16'd10000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Mostly short frames; now and then a full one or a count above the limit.
    function automatic logic [5:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 6'($urandom_range(56, 63));
        end else if (r < 20) begin
            return 6'($urandom_range(7, 20));
        end
        return 6'($urandom_range(0, 6));
    endfunction

    // Well-formed frames with random content, some cut short by a new start,
    // and stray samples after a closed frame.
    task automatic run_frames(int target);
        int goal;
        int full;
        int stop_at;
        logic [5:0] count;
        goal = items_sent + target;
        while (items_sent < goal) begin
            count = rand_count();
            full  = (count > arfb_pkg::ARFB_MAX_SAMPLES) ? arfb_pkg::ARFB_MAX_SAMPLES : count;
            stop_at = full;
            if (full > 0 && $urandom_range(0, 99) < 8) begin
                stop_at = $urandom_range(0, full - 1);
            end
            send_start(count);
            for (int k = 0; k < stop_at; k++) begin
                send_sample(rand_sample());
            end
            if (stop_at == full && $urandom_range(0, 99) < 10) begin
                send_sample(rand_sample());
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = arfb_pkg::ARFB_CMD_START;
        in_ch.err_code     = '0;
        in_ch.power_level  = '0;
        in_ch.sample_count = '0;
        in_ch.sample       = '0;
        out_ch.ready       = 1'b0;
        in_idle_pct        = 32;
        out_idle_pct       = 86;
        items_sent         = 0;
        quiet_cycles       = 0;
        board              = new();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest fields, a sample with no frame, empty and short frames.
        set_config(0, 0);
        send_sample(16'h1234);
        send_item(arfb_pkg::ARFB_CMD_START, 7'd0, 10'd0, 6'd0, 16'h0000);
        send_item(arfb_pkg::ARFB_CMD_START, 7'd99, 10'd999, 6'd1, 16'hFFFF);
        send_sample(16'd0);

        // Directed: saturated fields, stray sample, oversized count, abandoned frame.
        set_config(1023, 127);
        send_item(arfb_pkg::ARFB_CMD_START, 7'd127, 10'd1023, 6'd2, 16'h0000);
        send_sample(16'd9999);
        send_sample(16'hFFFF);
        send_sample(16'hAAAA);
        send_item(arfb_pkg::ARFB_CMD_START, 7'd50, 10'd500, 6'd63, 16'h5555);
        send_sample(16'd10000);
        send_item(arfb_pkg::ARFB_CMD_START, 7'd7, 10'd42, 6'd3, 16'h0000);
        send_sample(16'd1234);
        send_sample(16'h5555);
        send_sample(16'd8);

        // Random segments over several settings and idling patterns.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: set_config(999, 99);
                2: set_config(1, 9);
                4: set_config(1023, 0);
                default: set_config($urandom_range(0, 1023), $urandom_range(0, 127));
            endcase
            if (seg < 2) begin
                in_idle_pct  = 32;
                out_idle_pct = 86;
            end else if (seg < 4) begin
                in_idle_pct  = 86;
                out_idle_pct = 32;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            run_frames(RANDOM_ITEMS / SEGMENTS);
        end

        settle();
        if (board.errors == 0 && board.expected_bytes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ ascii_report_frame_builder.f @@
src/arfb_pkg.sv
src/arfb_in_if.sv
src/arfb_out_if.sv
src/arfb_front.sv
src/arfb_fifo.sv
src/arfb_back.sv
src/ascii_report_frame_builder.sv
src/arfb_checker.sv
test/tb_ascii_report_frame_builder.sv
